@@ src/cosk_pkg.sv @@
`timescale 1ns / 1ps
package cosk_pkg;

	typedef enum logic [2:0] {
		SH_0,
		SH_16,
		SH_24,
		SH_40,
		SH_56
	} shift_t;

	typedef struct packed {
		logic [63:0] a;
		logic        a_sgn;
		logic [63:0] b;
		logic        b_sgn;
		shift_t      sh;
	} mul_req_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_DECODE,
		S_SEED_A,
		S_SEED_B,
		S_GAP,
		S_CHECK,
		S_CV_MUL,
		S_CV_RND,
		S_CV_FIN,
		S_U_PRED,
		S_U_RES,
		S_U_GATE,
		S_U_U,
		S_U_C01,
		S_U_SQ1,
		S_U_C11,
		S_U_A1,
		S_U_A2,
		S_U_SQ0,
		S_U_A3,
		S_U_C00,
		S_U_SQM,
		S_U_S,
		S_U_K0,
		S_U_K1,
		S_U_OFF,
		S_U_SKW,
		S_U_P00,
		S_U_P01,
		S_U_P10,
		S_U_P11,
		S_DONE
	} state_t;

	localparam logic [1:0] OP_UPDATE  = 2'd0;
	localparam logic [1:0] OP_CONVERT = 2'd1;
	localparam logic [1:0] OP_RESET   = 2'd2;

	localparam logic [2:0] ST_SEEDED    = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_TOO_SOON  = 3'd2;
	localparam logic [2:0] ST_OUTLIER   = 3'd3;
	localparam logic [2:0] ST_CONVERTED = 3'd4;
	localparam logic [2:0] ST_RESET     = 3'd5;

	localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
	localparam logic [2:0] REG_MEAS_SIGMA   = 3'd1;
	localparam logic [2:0] REG_INIT_OFFSET  = 3'd2;
	localparam logic [2:0] REG_INIT_SKEW    = 3'd3;
	localparam logic [2:0] REG_OFFSET_NOISE = 3'd4;
	localparam logic [2:0] REG_SKEW_NOISE   = 3'd5;

	localparam logic [31:0] RST_MIN_INTERVAL = 32'd10000000;
	localparam logic [31:0] RST_MEAS_SIGMA   = 32'd1000000;
	localparam logic [31:0] RST_INIT_OFFSET  = 32'd1000000000;
	localparam logic [31:0] RST_INIT_SKEW    = 32'd4294967;
	localparam logic [31:0] RST_OFFSET_NOISE = 32'd1000;
	localparam logic [31:0] RST_SKEW_NOISE   = 32'd43;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	function automatic logic signed [127:0] ext128(input logic signed [63:0] x);
		return {{64{x[63]}}, x};
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [127:0] x);
		if (x[127:63] == {65{x[127]}}) begin
			return x[63:0];
		end
		return x[127] ? S64_MIN : S64_MAX;
	endfunction

endpackage

@@ src/cosk_mul.sv @@
`timescale 1ns / 1ps
module cosk_mul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  cosk_pkg::mul_req_t     req,
	output logic                   done,
	output logic signed [127:0]    res
);
	import cosk_pkg::*;

	localparam logic [2:0] CNT_NEG = 3'd4;
	localparam logic [2:0] CNT_RND = 3'd5;

	logic [63:0]           am_q, bm_q;
	logic                  neg_q;
	shift_t                sh_q;
	logic signed [127:0]   acc_q;
	logic signed [127:0]   res_q;
	logic [2:0]            cnt_q;
	logic                  busy_q, done_q;
	logic                  a_neg, b_neg;
	logic [31:0]           pa, pb;
	logic [63:0]           pp;
	logic [127:0]          pp_sh;
	logic signed [127:0]   rnd;

	always_comb begin
		a_neg = req.a_sgn & req.a[63];
		b_neg = req.b_sgn & req.b[63];
		pa = am_q[{cnt_q[1], 5'd0} +: 32];
		pb = bm_q[{cnt_q[0], 5'd0} +: 32];
		pp = pa * pb;
		unique case (cnt_q[1:0])
			2'd0: pp_sh = {64'd0, pp};
			2'd3: pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		unique case (sh_q)
			SH_16: rnd = (acc_q + (128'sd1 <<< 15)) >>> 16;
			SH_24: rnd = (acc_q + (128'sd1 <<< 23)) >>> 24;
			SH_40: rnd = (acc_q + (128'sd1 <<< 39)) >>> 40;
			SH_56: rnd = (acc_q + (128'sd1 <<< 55)) >>> 56;
			default: rnd = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				am_q <= a_neg ? (64'd0 - req.a) : req.a;
				bm_q <= b_neg ? (64'd0 - req.b) : req.b;
				neg_q <= a_neg ^ b_neg;
				sh_q <= req.sh;
				acc_q <= '0;
				cnt_q <= 3'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q < CNT_NEG) begin
					acc_q <= acc_q + $signed(pp_sh);
				end else if (cnt_q == CNT_NEG) begin
					if (neg_q) begin
						acc_q <= -acc_q;
					end
				end else if (cnt_q == CNT_RND) begin
					res_q <= rnd;
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

@@ src/cosk_div.sv @@
`timescale 1ns / 1ps
module cosk_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [127:0]   num,
	input  logic signed [63:0]    den,
	output logic                  done,
	output logic signed [63:0]    quo
);
	import cosk_pkg::*;

	logic [127:0]         n_q;
	logic [64:0]          rem_q;
	logic [63:0]          d_q;
	logic                 neg_q;
	logic [6:0]           cnt_q;
	logic                 busy_q, fin_q, done_q;
	logic signed [63:0]   quo_q;
	logic [64:0]          rem2;
	logic                 fits;

	always_comb begin
		rem2 = {rem_q[63:0], n_q[127]};
		fits = rem2 >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q <= num[127];
				n_q <= num[127] ? -num : num;
				d_q <= den;
				rem_q <= '0;
				cnt_q <= 7'd0;
				busy_q <= 1'b1;
				fin_q <= 1'b0;
			end else if (busy_q && !fin_q) begin
				rem_q <= fits ? (rem2 - {1'b0, d_q}) : rem2;
				n_q <= {n_q[126:0], fits};
				cnt_q <= cnt_q + 7'd1;
				if (&cnt_q) begin
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				if (|n_q[127:63]) begin
					quo_q <= neg_q ? S64_MIN : S64_MAX;
				end else begin
					quo_q <= neg_q ? -$signed(n_q[63:0]) : $signed(n_q[63:0]);
				end
				fin_q <= 1'b0;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ src/clock_offset_skew_kalman.sv @@
`timescale 1ns / 1ps
// A full update makes fifteen passes through the shared multiplier and two runs of the divider for
// the gains. Other items are reset, too soon, convert, outlier, seeding update and convert that
// seeds first; a stalled output holds the filter in its done state until the result is registered.
// One item at a time: the next is taken in the cycle after the result is registered.
// Asynchronous active-low reset stops the filter, clears its state and loads register defaults.
module clock_offset_skew_kalman #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic signed [63:0]  dev_stamp,
	input  logic signed [63:0]  loc_stamp,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [63:0]  local_estimate,
	output logic [2:0]          status,
	output logic signed [63:0]  offset_estimate,
	output logic signed [63:0]  skew_estimate
);
	import cosk_pkg::*;

	localparam int TSH = 64 - TIME_WIDTH;
	localparam logic signed [63:0] T_MAX = (64'sd1 <<< (TIME_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] T_MIN = -T_MAX - 64'sd1;

	function automatic logic signed [63:0] fold(input logic [63:0] v);
		logic signed [63:0] t;
		t = $signed(v << TSH);
		return t >>> TSH;
	endfunction

	state_t                state_q, state_d;
	logic                  wait_q;
	logic [31:0]           min_int_q, meas_q, ioff_q, iskew_q, noff_q, nskew_q;
	logic                  running_q;
	logic signed [63:0]    offset_q, skew_q, p00_q, p01_q, p10_q, p11_q, last_q;
	logic [1:0]            op_q;
	logic signed [63:0]    dev_q, loc_q, dt_q, pred_q, rq_q, u_q;
	logic signed [63:0]    c00_q, c01_q, c10_q, c11_q, s_q, k0_q, k1_q, est_q;
	logic [63:0]           sq_q;
	logic signed [127:0]   acc_q;
	logic [2:0]            status_q;
	logic                  out_valid_q;
	logic signed [63:0]    out_est_q, out_off_q, out_skew_q;
	logic [2:0]            out_status_q;

	logic                  is_mul, is_div, mul_start, div_start, mul_done, div_done;
	mul_req_t              mreq;
	logic signed [127:0]   mres, div_num;
	logic signed [63:0]    div_quo, est_sat, est_clamp, s_val;
	logic                  too_soon, outlier, out_free, cfg_wr;

	cosk_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.req    (mreq),
		.done   (mul_done),
		.res    (mres)
	);

	cosk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[4:2])
			REG_MIN_INTERVAL: prdata = min_int_q;
			REG_MEAS_SIGMA:   prdata = meas_q;
			REG_INIT_OFFSET:  prdata = ioff_q;
			REG_INIT_SKEW:    prdata = iskew_q;
			REG_OFFSET_NOISE: prdata = noff_q;
			REG_SKEW_NOISE:   prdata = nskew_q;
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_int_q <= RST_MIN_INTERVAL;
			meas_q <= RST_MEAS_SIGMA;
			ioff_q <= RST_INIT_OFFSET;
			iskew_q <= RST_INIT_SKEW;
			noff_q <= RST_OFFSET_NOISE;
			nskew_q <= RST_SKEW_NOISE;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_MIN_INTERVAL: min_int_q <= pwdata;
				REG_MEAS_SIGMA:   meas_q <= pwdata;
				REG_INIT_OFFSET:  ioff_q <= pwdata;
				REG_INIT_SKEW:    iskew_q <= pwdata;
				REG_OFFSET_NOISE: noff_q <= pwdata;
				REG_SKEW_NOISE:   nskew_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		too_soon = dt_q[63] || (dt_q[62:0] < {31'd0, min_int_q});
		outlier = acc_q > $signed({79'd0, meas_q, 17'd0});
		est_sat = sat64(acc_q >>> 16);
		if (est_sat > T_MAX) begin
			est_clamp = T_MAX;
		end else if (est_sat < T_MIN) begin
			est_clamp = T_MIN;
		end else begin
			est_clamp = est_sat;
		end
		s_val = sat64(acc_q);
		out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (op_q == OP_RESET) begin
					state_d = S_DONE;
				end else if (op_q == OP_UPDATE || op_q == OP_CONVERT) begin
					state_d = running_q ? S_GAP : S_SEED_A;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SEED_A: if (mul_done) state_d = S_SEED_B;
			S_SEED_B: if (mul_done) state_d = (op_q == OP_UPDATE) ? S_DONE : S_GAP;
			S_GAP:    state_d = (op_q == OP_CONVERT) ? S_CV_MUL : S_CHECK;
			S_CHECK:  state_d = too_soon ? S_DONE : S_U_PRED;
			S_CV_MUL: if (mul_done) state_d = S_CV_RND;
			S_CV_RND: state_d = S_CV_FIN;
			S_CV_FIN: state_d = S_DONE;
			S_U_PRED: if (mul_done) state_d = S_U_RES;
			S_U_RES:  state_d = S_U_GATE;
			S_U_GATE: state_d = outlier ? S_DONE : S_U_U;
			S_U_U:    if (mul_done) state_d = S_U_C01;
			S_U_C01:  state_d = S_U_SQ1;
			S_U_SQ1:  if (mul_done) state_d = S_U_C11;
			S_U_C11:  if (mul_done) state_d = S_U_A1;
			S_U_A1:   if (mul_done) state_d = S_U_A2;
			S_U_A2:   if (mul_done) state_d = S_U_SQ0;
			S_U_SQ0:  if (mul_done) state_d = S_U_A3;
			S_U_A3:   if (mul_done) state_d = S_U_C00;
			S_U_C00:  state_d = S_U_SQM;
			S_U_SQM:  if (mul_done) state_d = S_U_S;
			S_U_S:    state_d = S_U_K0;
			S_U_K0:   if (div_done) state_d = S_U_K1;
			S_U_K1:   if (div_done) state_d = S_U_OFF;
			S_U_OFF:  if (mul_done) state_d = S_U_SKW;
			S_U_SKW:  if (mul_done) state_d = S_U_P00;
			S_U_P00:  if (mul_done) state_d = S_U_P01;
			S_U_P01:  if (mul_done) state_d = S_U_P10;
			S_U_P10:  if (mul_done) state_d = S_U_P11;
			S_U_P11:  if (mul_done) state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		is_mul = 1'b1;
		is_div = 1'b0;
		mreq.a = dt_q;
		mreq.a_sgn = 1'b1;
		mreq.b = skew_q;
		mreq.b_sgn = 1'b1;
		mreq.sh = SH_0;
		div_num = ext128(c00_q) <<< 40;
		unique case (state_q)
			S_SEED_A: begin
				mreq.a = {32'd0, ioff_q};
				mreq.b = {32'd0, ioff_q};
				mreq.sh = SH_16;
			end
			S_SEED_B: begin
				mreq.a = {32'd0, iskew_q};
				mreq.b = {32'd0, iskew_q};
			end
			S_CV_MUL, S_U_PRED: mreq.sh = SH_24;
			S_U_U: begin
				mreq.b = p11_q;
				mreq.sh = SH_40;
			end
			S_U_SQ1: begin
				mreq.a = {32'd0, nskew_q};
				mreq.b = {32'd0, nskew_q};
			end
			S_U_C11: begin
				mreq.b = sq_q;
				mreq.b_sgn = 1'b0;
			end
			S_U_A1: begin
				mreq.b = p10_q;
				mreq.sh = SH_40;
			end
			S_U_A2: begin
				mreq.b = c01_q;
				mreq.sh = SH_40;
			end
			S_U_SQ0: begin
				mreq.a = {32'd0, noff_q};
				mreq.b = {32'd0, noff_q};
			end
			S_U_A3: begin
				mreq.b = sq_q;
				mreq.b_sgn = 1'b0;
				mreq.sh = SH_16;
			end
			S_U_SQM: begin
				mreq.a = {32'd0, meas_q};
				mreq.b = {32'd0, meas_q};
				mreq.sh = SH_16;
			end
			S_U_K0: begin
				is_mul = 1'b0;
				is_div = 1'b1;
			end
			S_U_K1: begin
				is_mul = 1'b0;
				is_div = 1'b1;
				div_num = ext128(c10_q) <<< 40;
			end
			S_U_OFF: begin
				mreq.a = k0_q;
				mreq.b = rq_q;
				mreq.sh = SH_40;
			end
			S_U_SKW: begin
				mreq.a = k1_q;
				mreq.b = rq_q;
				mreq.sh = SH_56;
			end
			S_U_P00: begin
				mreq.a = k0_q;
				mreq.b = c00_q;
				mreq.sh = SH_40;
			end
			S_U_P01: begin
				mreq.a = k0_q;
				mreq.b = c01_q;
				mreq.sh = SH_40;
			end
			S_U_P10: begin
				mreq.a = k1_q;
				mreq.b = c00_q;
				mreq.sh = SH_40;
			end
			S_U_P11: begin
				mreq.a = k1_q;
				mreq.b = c01_q;
				mreq.sh = SH_40;
			end
			default: is_mul = 1'b0;
		endcase
		mul_start = is_mul && !wait_q;
		div_start = is_div && !wait_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				wait_q <= 1'b1;
			end else if (mul_done || div_done) begin
				wait_q <= 1'b0;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			offset_q <= '0;
			skew_q <= '0;
			p00_q <= '0;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= '0;
			last_q <= '0;
		end else begin
			unique case (state_q)
				S_DECODE: if (op_q == OP_RESET) running_q <= 1'b0;
				S_SEED_A: if (mul_done) p00_q <= sat64(mres);
				S_SEED_B: begin
					if (mul_done) begin
						p11_q <= sat64(mres);
						p01_q <= '0;
						p10_q <= '0;
						offset_q <= sat64((ext128(loc_q) - ext128(dev_q)) <<< 16);
						skew_q <= '0;
						last_q <= dev_q;
						running_q <= 1'b1;
					end
				end
				S_U_OFF: if (mul_done) offset_q <= sat64(ext128(pred_q) + mres);
				S_U_SKW: if (mul_done) skew_q <= sat64(ext128(skew_q) + mres);
				S_U_P00: if (mul_done) p00_q <= sat64(ext128(c00_q) - mres);
				S_U_P01: if (mul_done) p01_q <= sat64(ext128(c01_q) - mres);
				S_U_P10: if (mul_done) p10_q <= sat64(ext128(c10_q) - mres);
				S_U_P11: begin
					if (mul_done) begin
						p11_q <= sat64(ext128(c11_q) - mres);
						last_q <= dev_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q <= op;
					dev_q <= fold(dev_stamp);
					loc_q <= fold(loc_stamp);
				end
			end
			S_DECODE: begin
				est_q <= '0;
				status_q <= ST_RESET;
			end
			S_SEED_B: if (mul_done) status_q <= ST_SEEDED;
			S_GAP: begin
				dt_q <= fold(dev_q - last_q);
				acc_q <= (ext128(dev_q) <<< 16) + ext128(offset_q);
			end
			S_CHECK:  status_q <= ST_TOO_SOON;
			S_CV_MUL: if (mul_done) acc_q <= acc_q + mres;
			S_CV_RND: acc_q <= acc_q + (128'sd1 <<< 15);
			S_CV_FIN: begin
				est_q <= est_clamp;
				status_q <= ST_CONVERTED;
			end
			S_U_PRED: if (mul_done) pred_q <= sat64(ext128(offset_q) + mres);
			S_U_RES:  acc_q <= ((ext128(loc_q) - ext128(dev_q)) <<< 16) - ext128(pred_q);
			S_U_GATE: begin
				status_q <= ST_OUTLIER;
				rq_q <= sat64(acc_q);
			end
			S_U_U: if (mul_done) u_q <= sat64(mres);
			S_U_C01: begin
				c01_q <= sat64(ext128(p01_q) + ext128(u_q));
				c10_q <= sat64(ext128(p10_q) + ext128(u_q));
			end
			S_U_SQ1, S_U_SQ0: if (mul_done) sq_q <= mres[63:0];
			S_U_C11: if (mul_done) c11_q <= sat64(ext128(p11_q) + mres);
			S_U_A1:  if (mul_done) acc_q <= ext128(p00_q) + mres;
			S_U_A2, S_U_A3: if (mul_done) acc_q <= acc_q + mres;
			S_U_C00: c00_q <= sat64(acc_q);
			S_U_SQM: if (mul_done) acc_q <= ext128(c00_q) + mres;
			S_U_S:   s_q <= (s_val < 64'sd1) ? 64'sd1 : s_val;
			S_U_K0:  if (div_done) k0_q <= div_quo;
			S_U_K1:  if (div_done) k1_q <= div_quo;
			S_U_P11: if (mul_done) status_q <= ST_UPDATED;
			S_DONE: begin
				if (out_free) begin
					out_est_q <= est_q;
					out_status_q <= status_q;
					out_off_q <= offset_q;
					out_skew_q <= skew_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign local_estimate = out_est_q;
	assign status = out_status_q;
	assign offset_estimate = out_off_q;
	assign skew_estimate = out_skew_q;

endmodule
